/* hw/rtl/i2c_rm_pkg.sv */
package i2c_rm_pkg;

   localparam logic [7:0] REG_STEP       = 8'h00;
   localparam logic [7:0] REG_LED_CONFIG = 8'h10;
   localparam logic [7:0] REG_LED_LIGHT  = 8'h20;
   localparam logic [7:0] REG_LED_SWITCH = 8'h30;
   localparam logic [7:0] REG_RGB_MODE   = 8'h40;
   localparam logic [7:0] REG_RGB_LEVEL  = 8'h41;
   localparam logic [7:0] REG_COLOUR_0   = 8'h50;
   localparam logic [7:0] REG_COLOUR_1   = 8'h51;
   localparam logic [7:0] REG_COLOUR_2   = 8'h52;
   localparam logic [7:0] REG_SAVE       = 8'hF0;
   localparam logic [7:0] REG_UPDATE     = 8'hFD;
   localparam logic [7:0] REG_FW_VERSION = 8'hFE;
   localparam logic [7:0] REG_BUS_ADDR   = 8'hFF;

   localparam logic [7:0] ADDR_MIN  = 8'h08;
   localparam logic [7:0] ADDR_MAX  = 8'h77;
   localparam logic [7:0] LIMIT_100 = 8'd100;
   localparam logic [9:0] MS_PER_UNIT = 10'd1000;

   localparam logic [7:0] FW_VERSION_DEFAULT  = 8'h01;
   localparam logic [7:0] LED_CONFIG_DEFAULT  = 8'hFE;
   localparam logic [6:0] LEVEL_DEFAULT       = 7'h32;
   localparam logic [6:0] BUS_ADDRESS_DEFAULT = 7'h48;
   localparam logic [7:0] RGB_MODE_DEFAULT    = 8'h01;

   localparam logic [1:0] SAVE_NONE = 2'd0;
   localparam logic [1:0] SAVE_STEP = 2'd1;
   localparam logic [1:0] SAVE_RGB  = 2'd2;

   localparam logic [7:0] SAVE_CMD_STEP = 8'd1;
   localparam logic [7:0] SAVE_CMD_RGB  = 8'd2;

   typedef struct packed {
      logic       mode;
      logic [7:0] step_value;
      logic [7:0] reg_addr;
      logic [3:0] byte_count;
      logic [7:0] data_first;
      logic [7:0] data_second;
      logic [7:0] data_third;
   } req_type;

   typedef struct packed {
      logic [1:0]  read_len;
      logic [7:0]  read_first;
      logic [7:0]  read_second;
      logic [7:0]  read_third;
      logic [17:0] led_timeout_ms;
      logic [1:0]  save_request;
      logic        address_changed;
      logic [6:0]  device_address;
      logic        update_request;
      logic        colour_changed;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctrl_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

/* hw/rtl/i2c_rm_req_if.sv */
interface i2c_rm_req_if import i2c_rm_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/i2c_rm_rsp_if.sv */
interface i2c_rm_rsp_if import i2c_rm_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/i2c_rm_ctrl.sv */
module i2c_rm_ctrl import i2c_rm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.execute = status.out_free;
         end
         default: ;
      endcase
   end

endmodule

/* hw/rtl/i2c_rm_dp.sv */
module i2c_rm_dp import i2c_rm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   input  req_type         req_payload,
   input  logic            csr_we,
   input  logic [7:0]      csr_wdata,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output rsp_type         rsp_payload
);

   req_type     item_ff;
   logic [7:0]  fw_version_ff;
   logic [7:0]  step_now_ff,    step_now_in;
   logic [7:0]  led_config_ff,  led_config_in;
   logic [6:0]  led_light_ff,   led_light_in;
   logic        led_switch_ff,  led_switch_in;
   logic [7:0]  rgb_mode_ff,    rgb_mode_in;
   logic [7:0]  rgb_level_ff,   rgb_level_in;
   logic [7:0]  colour_ff [3];
   logic [7:0]  colour_in [3];
   logic [6:0]  bus_address_ff, bus_address_in;
   logic [15:0] saved_step_ff,  saved_step_in;
   logic [15:0] saved_rgb_ff,   saved_rgb_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff,         rsp_in;

   logic        is_write, is_read, len_two, rgb_burst, colour_burst;
   logic [7:0]  d0, d1, d2;
   logic [1:0]  off;
   logic [15:0] step_pack, rgb_pack;

   // true when burst position pos lies inside the data bytes of the transfer
   function automatic logic burst_hit(input logic [1:0] pos, input logic [3:0] len);
      burst_hit = ({2'b00, pos} + 4'd1) < len;
   endfunction

   function automatic logic [7:0] pick(input logic [1:0] pos, input logic [7:0] a,
                                       input logic [7:0] b, input logic [7:0] c);
      case (pos)
         2'd0:    pick = a;
         2'd1:    pick = b;
         default: pick = c;
      endcase
   endfunction

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_payload;
      if (cmd.execute) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_version_ff <= FW_VERSION_DEFAULT;
      end else if (csr_we) begin
         fw_version_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_now_ff    <= 8'd0;
         led_config_ff  <= LED_CONFIG_DEFAULT;
         led_light_ff   <= LEVEL_DEFAULT;
         led_switch_ff  <= 1'b1;
         rgb_mode_ff    <= RGB_MODE_DEFAULT;
         rgb_level_ff   <= {1'b0, LEVEL_DEFAULT};
         colour_ff[0]   <= 8'd0;
         colour_ff[1]   <= 8'd0;
         colour_ff[2]   <= 8'd0;
         bus_address_ff <= BUS_ADDRESS_DEFAULT;
         saved_step_ff  <= {LED_CONFIG_DEFAULT, LEVEL_DEFAULT, 1'b1};
         saved_rgb_ff   <= {RGB_MODE_DEFAULT, 1'b0, LEVEL_DEFAULT};
      end else if (cmd.execute) begin
         step_now_ff    <= step_now_in;
         led_config_ff  <= led_config_in;
         led_light_ff   <= led_light_in;
         led_switch_ff  <= led_switch_in;
         rgb_mode_ff    <= rgb_mode_in;
         rgb_level_ff   <= rgb_level_in;
         colour_ff[0]   <= colour_in[0];
         colour_ff[1]   <= colour_in[1];
         colour_ff[2]   <= colour_in[2];
         bus_address_ff <= bus_address_in;
         saved_step_ff  <= saved_step_in;
         saved_rgb_ff   <= saved_rgb_in;
      end
   end

   always_comb begin
      d0           = item_ff.data_first;
      d1           = item_ff.data_second;
      d2           = item_ff.data_third;
      is_write     = !item_ff.mode && (item_ff.byte_count > 4'd1);
      is_read      = !item_ff.mode && (item_ff.byte_count == 4'd1);
      len_two      = item_ff.byte_count == 4'd2;
      off          = item_ff.reg_addr[1:0];
      rgb_burst    = (item_ff.reg_addr == REG_RGB_MODE || item_ff.reg_addr == REG_RGB_LEVEL)
                     && (item_ff.byte_count <= 4'd3);
      colour_burst = (item_ff.reg_addr == REG_COLOUR_0 || item_ff.reg_addr == REG_COLOUR_1
                      || item_ff.reg_addr == REG_COLOUR_2) && (item_ff.byte_count <= 4'd4);
      step_pack    = {led_config_ff, led_light_ff, led_switch_ff};
      rgb_pack     = {rgb_mode_ff, rgb_level_ff};

      step_now_in    = step_now_ff;
      led_config_in  = led_config_ff;
      led_light_in   = led_light_ff;
      led_switch_in  = led_switch_ff;
      rgb_mode_in    = rgb_mode_ff;
      rgb_level_in   = rgb_level_ff;
      colour_in[0]   = colour_ff[0];
      colour_in[1]   = colour_ff[1];
      colour_in[2]   = colour_ff[2];
      bus_address_in = bus_address_ff;
      saved_step_in  = saved_step_ff;
      saved_rgb_in   = saved_rgb_ff;

      rsp_in.read_len        = 2'd0;
      rsp_in.read_first      = 8'd0;
      rsp_in.read_second     = 8'd0;
      rsp_in.read_third      = 8'd0;
      rsp_in.save_request    = SAVE_NONE;
      rsp_in.address_changed = 1'b0;
      rsp_in.update_request  = 1'b0;
      rsp_in.colour_changed  = 1'b0;

      if (item_ff.mode) begin
         step_now_in = item_ff.step_value;
      end else if (is_write) begin
         if (item_ff.reg_addr == REG_LED_CONFIG && len_two) begin
            led_config_in = d0;
         end else if (item_ff.reg_addr == REG_LED_LIGHT && len_two) begin
            if (d0 <= LIMIT_100) led_light_in = d0[6:0];
         end else if (item_ff.reg_addr == REG_LED_SWITCH && len_two) begin
            if (d0 <= 8'd1) led_switch_in = d0[0];
         end else if (item_ff.reg_addr == REG_BUS_ADDR && len_two) begin
            if (d0 >= ADDR_MIN && d0 <= ADDR_MAX && d0[6:0] != bus_address_ff) begin
               bus_address_in         = d0[6:0];
               rsp_in.address_changed = 1'b1;
            end
         end else if (rgb_burst) begin
            if (!off[0]) begin
               rgb_mode_in = d0;
               if (item_ff.byte_count == 4'd3 && d1 <= LIMIT_100) rgb_level_in = d1;
            end else if (d0 <= LIMIT_100) begin
               rgb_level_in = d0;
            end
         end else if (colour_burst) begin
            for (int c = 0; c < 3; c++) begin
               if (2'(c) >= off && burst_hit(2'(c) - off, item_ff.byte_count)
                   && pick(2'(c) - off, d0, d1, d2) != colour_ff[c]) begin
                  colour_in[c]          = pick(2'(c) - off, d0, d1, d2);
                  rsp_in.colour_changed = 1'b1;
               end
            end
         end else if (item_ff.reg_addr == REG_UPDATE && len_two) begin
            rsp_in.update_request = d0 != 8'd0;
         end else if (item_ff.reg_addr == REG_SAVE && len_two) begin
            if (d0 == SAVE_CMD_STEP && step_pack != saved_step_ff) begin
               saved_step_in       = step_pack;
               rsp_in.save_request = SAVE_STEP;
            end else if (d0 == SAVE_CMD_RGB && rgb_pack != saved_rgb_ff) begin
               saved_rgb_in        = rgb_pack;
               rsp_in.save_request = SAVE_RGB;
            end
         end
      end else if (is_read) begin
         case (item_ff.reg_addr)
            REG_STEP: begin
               rsp_in.read_len = 2'd1; rsp_in.read_first = step_now_ff;
            end
            REG_LED_CONFIG: begin
               rsp_in.read_len = 2'd1; rsp_in.read_first = led_config_ff;
            end
            REG_LED_LIGHT: begin
               rsp_in.read_len = 2'd1; rsp_in.read_first = {1'b0, led_light_ff};
            end
            REG_LED_SWITCH: begin
               rsp_in.read_len = 2'd1; rsp_in.read_first = {7'd0, led_switch_ff};
            end
            REG_RGB_MODE: begin
               rsp_in.read_len    = 2'd2;
               rsp_in.read_first  = rgb_mode_ff;
               rsp_in.read_second = rgb_level_ff;
            end
            REG_RGB_LEVEL: begin
               rsp_in.read_len = 2'd1; rsp_in.read_first = rgb_level_ff;
            end
            REG_COLOUR_0: begin
               rsp_in.read_len    = 2'd3;
               rsp_in.read_first  = colour_ff[0];
               rsp_in.read_second = colour_ff[1];
               rsp_in.read_third  = colour_ff[2];
            end
            REG_COLOUR_1: begin
               rsp_in.read_len    = 2'd2;
               rsp_in.read_first  = colour_ff[1];
               rsp_in.read_second = colour_ff[2];
            end
            REG_COLOUR_2: begin
               rsp_in.read_len = 2'd1; rsp_in.read_first = colour_ff[2];
            end
            REG_FW_VERSION: begin
               rsp_in.read_len = 2'd1; rsp_in.read_first = fw_version_ff;
            end
            REG_BUS_ADDR: begin
               rsp_in.read_len = 2'd1; rsp_in.read_first = {1'b0, bus_address_ff};
            end
            default: ;
         endcase
      end

      rsp_in.led_timeout_ms = 18'(led_config_in) * 18'(MS_PER_UNIT);
      rsp_in.device_address = bus_address_in;
   end

endmodule

/* hw/rtl/i2c_register_map_slave_core.sv */
// an accepted transfer is captured first, then decoded and its response registered
// once the response register is free; a new transfer is taken only after that
// the response register frees the input side once its transfer completes
// reset: synchronous active-high reset loads the default register values,
// the saved-value shadows and firmware version 1, and empties the response register
module i2c_register_map_slave_core import i2c_rm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   i2c_rm_req_if.sink   req_chan,
   i2c_rm_rsp_if.source rsp_chan,
   input  logic         csr_we,
   input  logic [7:0]   csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   i2c_rm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   i2c_rm_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_chan.payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_payload (rsp_chan.payload)
   );

endmodule

/* sim/i2c_register_map_slave_core_tb.sv */
`timescale 1ns / 1ps

module i2c_register_map_slave_core_tb;
   import i2c_rm_pkg::*;

   localparam logic [7:0] KNOWN_REGS [13] = '{
      REG_STEP, REG_LED_CONFIG, REG_LED_LIGHT, REG_LED_SWITCH, REG_RGB_MODE,
      REG_RGB_LEVEL, REG_COLOUR_0, REG_COLOUR_1, REG_COLOUR_2, REG_SAVE,
      REG_UPDATE, REG_FW_VERSION, REG_BUS_ADDR
   };
   localparam logic [7:0] BOUNDARY_BYTES [13] = '{
      8'h00, 8'h01, 8'h02, 8'h07, 8'h08, 8'd99, 8'd100, 8'd101,
      8'h77, 8'h78, 8'h7F, 8'h80, 8'hFF
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;

   i2c_rm_req_if req_if ();
   i2c_rm_rsp_if rsp_if ();

   i2c_register_map_slave_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mirror of the register map
   logic [7:0]  mirror_fw;
   logic [7:0]  mirror_step;
   logic [7:0]  mirror_led_cfg;
   logic [6:0]  mirror_light;
   logic        mirror_switch;
   logic [7:0]  mirror_rgb_mode;
   logic [7:0]  mirror_rgb_level;
   logic [7:0]  mirror_colour [3];
   logic [6:0]  mirror_addr;
   logic [15:0] shadow_step_grp;
   logic [15:0] shadow_rgb_grp;

   req_type bus_items [$];
   rsp_type pending_answers [$];

   bit idle_on = 1'b1;
   int send_gap;
   int recv_gap;
   int mismatches;
   int answers_checked;
   int reads_answered;
   int save_requests;
   int addr_changes;
   int fw_settings;

   initial begin
      mirror_fw        = FW_VERSION_DEFAULT;
      mirror_step      = 8'h00;
      mirror_led_cfg   = LED_CONFIG_DEFAULT;
      mirror_light     = LEVEL_DEFAULT;
      mirror_switch    = 1'b1;
      mirror_rgb_mode  = RGB_MODE_DEFAULT;
      mirror_rgb_level = {1'b0, LEVEL_DEFAULT};
      mirror_colour    = '{8'h00, 8'h00, 8'h00};
      mirror_addr      = BUS_ADDRESS_DEFAULT;
      shadow_step_grp  = {LED_CONFIG_DEFAULT, LEVEL_DEFAULT, 1'b1};
      shadow_rgb_grp   = {RGB_MODE_DEFAULT, 1'b0, LEVEL_DEFAULT};
   end

   function automatic rsp_type decode_transaction(req_type r);
      rsp_type     a;
      logic [7:0]  d [3];
      logic [7:0]  rb [3];
      logic [15:0] grp;
      int unsigned off;
      int unsigned k;
      int          i;
      a = '0;
      rb = '{8'h00, 8'h00, 8'h00};
      d[0] = r.data_first;
      d[1] = r.data_second;
      d[2] = r.data_third;
      if (r.mode) begin
         mirror_step = r.step_value;
      end else if (r.byte_count > 1) begin
         if (r.reg_addr == REG_LED_CONFIG && r.byte_count == 2) begin
            mirror_led_cfg = d[0];
         end else if (r.reg_addr == REG_LED_LIGHT && r.byte_count == 2) begin
            if (d[0] <= LIMIT_100) mirror_light = d[0][6:0];
         end else if (r.reg_addr == REG_LED_SWITCH && r.byte_count == 2) begin
            if (d[0] <= 8'd1) mirror_switch = d[0][0];
         end else if (r.reg_addr == REG_BUS_ADDR && r.byte_count == 2) begin
            if (d[0] >= ADDR_MIN && d[0] <= ADDR_MAX && d[0] != {1'b0, mirror_addr}) begin
               mirror_addr = d[0][6:0];
               a.address_changed = 1'b1;
            end
         end else if ((r.reg_addr == REG_RGB_MODE || r.reg_addr == REG_RGB_LEVEL)
                      && r.byte_count <= 3) begin
            off = 32'(r.reg_addr - REG_RGB_MODE);
            for (i = 0; i < int'(r.byte_count) - 1; i++) begin
               k = off + i;
               if (k == 0) begin
                  mirror_rgb_mode = d[i];
               end else if (k == 1 && d[i] <= LIMIT_100) begin
                  mirror_rgb_level = d[i];
               end
            end
         end else if (r.reg_addr >= REG_COLOUR_0 && r.reg_addr <= REG_COLOUR_2
                      && r.byte_count <= 4) begin
            off = 32'(r.reg_addr - REG_COLOUR_0);
            for (i = 0; i < int'(r.byte_count) - 1; i++) begin
               k = off + i;
               if (k < 3 && mirror_colour[k] != d[i]) begin
                  mirror_colour[k] = d[i];
                  a.colour_changed = 1'b1;
               end
            end
         end else if (r.reg_addr == REG_UPDATE && r.byte_count == 2) begin
            if (d[0] != 8'h00) a.update_request = 1'b1;
         end else if (r.reg_addr == REG_SAVE && r.byte_count == 2) begin
            if (d[0] == SAVE_CMD_STEP) begin
               grp = {mirror_led_cfg, mirror_light, mirror_switch};
               if (grp != shadow_step_grp) begin
                  shadow_step_grp = grp;
                  a.save_request = SAVE_STEP;
               end
            end else if (d[0] == SAVE_CMD_RGB) begin
               grp = {mirror_rgb_mode, mirror_rgb_level};
               if (grp != shadow_rgb_grp) begin
                  shadow_rgb_grp = grp;
                  a.save_request = SAVE_RGB;
               end
            end
         end
      end else if (r.byte_count == 1) begin
         case (r.reg_addr)
            REG_STEP: begin
               rb[0] = mirror_step;
               a.read_len = 2'd1;
            end
            REG_LED_CONFIG: begin
               rb[0] = mirror_led_cfg;
               a.read_len = 2'd1;
            end
            REG_LED_LIGHT: begin
               rb[0] = {1'b0, mirror_light};
               a.read_len = 2'd1;
            end
            REG_LED_SWITCH: begin
               rb[0] = {7'd0, mirror_switch};
               a.read_len = 2'd1;
            end
            REG_RGB_MODE: begin
               rb[0] = mirror_rgb_mode;
               rb[1] = mirror_rgb_level;
               a.read_len = 2'd2;
            end
            REG_RGB_LEVEL: begin
               rb[0] = mirror_rgb_level;
               a.read_len = 2'd1;
            end
            REG_COLOUR_0, REG_COLOUR_1, REG_COLOUR_2: begin
               // colour bytes from the offset up to the last one
               off = 32'(r.reg_addr - REG_COLOUR_0);
               a.read_len = 2'(3 - off);
               for (i = 0; i < 3 - off; i++) rb[i] = mirror_colour[off + i];
            end
            REG_FW_VERSION: begin
               rb[0] = mirror_fw;
               a.read_len = 2'd1;
            end
            REG_BUS_ADDR: begin
               rb[0] = {1'b0, mirror_addr};
               a.read_len = 2'd1;
            end
            default: ;
         endcase
      end
      a.read_first = rb[0];
      a.read_second = rb[1];
      a.read_third = rb[2];
      a.led_timeout_ms = 18'(mirror_led_cfg) * 18'(MS_PER_UNIT);
      a.device_address = mirror_addr;
      return a;
   endfunction

   function automatic void add_txn(logic [7:0] addr, logic [3:0] cnt, logic [7:0] d0,
                                   logic [7:0] d1, logic [7:0] d2);
      req_type r;
      r.mode = 1'b0;
      r.step_value = 8'($urandom);
      r.reg_addr = addr;
      r.byte_count = cnt;
      r.data_first = d0;
      r.data_second = d1;
      r.data_third = d2;
      bus_items.push_back(r);
   endfunction

   // sensor update, transaction fields are junk
   function automatic void add_step(logic [7:0] value);
      req_type r;
      r.mode = 1'b1;
      r.step_value = value;
      r.reg_addr = 8'($urandom);
      r.byte_count = 4'($urandom);
      r.data_first = 8'($urandom);
      r.data_second = 8'($urandom);
      r.data_third = 8'($urandom);
      bus_items.push_back(r);
   endfunction

   function automatic logic [7:0] pick_data();
      if ($urandom_range(0, 2) == 0) return 8'($urandom);
      return BOUNDARY_BYTES[$urandom_range(0, 12)];
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (bus_items.size() != 0 || req_if.valid || pending_answers.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(string label, logic [17:0] want, logic [17:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   // request side
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            pending_answers.push_back(decode_transaction(req_if.payload));
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (bus_items.size() == 0) begin
               req_if.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 2);
               req_if.valid <= 1'b0;
            end else begin
               req_if.payload <= bus_items.pop_front();
               req_if.valid <= 1'b1;
            end
         end
      end
   end

   // response side
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (pending_answers.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
            end else begin
               want = pending_answers.pop_front();
               check_field("read_len", 18'(want.read_len), 18'(got.read_len));
               check_field("read_first", 18'(want.read_first), 18'(got.read_first));
               check_field("read_second", 18'(want.read_second), 18'(got.read_second));
               check_field("read_third", 18'(want.read_third), 18'(got.read_third));
               check_field("led_timeout_ms", want.led_timeout_ms, got.led_timeout_ms);
               check_field("save_request", 18'(want.save_request),
                           18'(got.save_request));
               check_field("address_changed", 18'(want.address_changed),
                           18'(got.address_changed));
               check_field("device_address", 18'(want.device_address),
                           18'(got.device_address));
               check_field("update_request", 18'(want.update_request),
                           18'(got.update_request));
               check_field("colour_changed", 18'(want.colour_changed),
                           18'(got.colour_changed));
               answers_checked++;
               if (want.read_len != 2'd0) reads_answered++;
               if (want.save_request != SAVE_NONE) save_requests++;
               if (want.address_changed) addr_changes++;
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_if.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 2);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [7:0] fw_values [5];
      logic [7:0] addr;
      logic [7:0] d0;
      logic [3:0] cnt;
      int         pick;
      int         phase;
      fw_values = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'($urandom)};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 8'h00;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset values and the corner cases of each register
      add_txn(REG_FW_VERSION, 4'd1, 8'h00, 8'h00, 8'h00);
      add_txn(REG_BUS_ADDR, 4'd1, 8'h00, 8'h00, 8'h00);
      add_step(8'hFF);
      add_txn(REG_STEP, 4'd1, 8'h00, 8'h00, 8'h00);
      add_txn(8'h33, 4'd1, 8'h00, 8'h00, 8'h00);
      add_txn(REG_LED_CONFIG, 4'd0, 8'h12, 8'h00, 8'h00);
      add_txn(REG_LED_CONFIG, 4'd2, 8'h00, 8'h00, 8'h00);
      add_txn(REG_LED_CONFIG, 4'd2, 8'hFF, 8'h00, 8'h00);
      add_txn(REG_LED_LIGHT, 4'd2, LIMIT_100, 8'h00, 8'h00);
      add_txn(REG_LED_LIGHT, 4'd2, 8'd101, 8'h00, 8'h00);
      add_txn(REG_LED_SWITCH, 4'd2, 8'd2, 8'h00, 8'h00);
      add_txn(REG_LED_SWITCH, 4'd3, 8'h00, 8'h00, 8'h00);
      add_txn(REG_SAVE, 4'd2, SAVE_CMD_STEP, 8'h00, 8'h00);
      add_txn(REG_SAVE, 4'd2, SAVE_CMD_STEP, 8'h00, 8'h00);
      add_txn(REG_RGB_MODE, 4'd3, 8'hFF, 8'd101, 8'h00);
      add_txn(REG_RGB_MODE, 4'd4, 8'h00, 8'h00, 8'h00);
      add_txn(REG_RGB_LEVEL, 4'd3, LIMIT_100, 8'h77, 8'h00);
      add_txn(REG_RGB_MODE, 4'd1, 8'h00, 8'h00, 8'h00);
      add_txn(REG_SAVE, 4'd2, SAVE_CMD_RGB, 8'h00, 8'h00);
      add_txn(REG_SAVE, 4'd2, 8'd3, 8'h00, 8'h00);
      add_txn(REG_COLOUR_0, 4'd4, 8'h11, 8'h22, 8'h33);
      add_txn(REG_COLOUR_0, 4'd4, 8'h11, 8'h22, 8'h33);
      add_txn(REG_COLOUR_2, 4'd4, 8'hFF, 8'hEE, 8'hDD);
      add_txn(REG_COLOUR_1, 4'd5, 8'h00, 8'h00, 8'h00);
      add_txn(REG_COLOUR_0, 4'd1, 8'h00, 8'h00, 8'h00);
      add_txn(REG_COLOUR_2, 4'd1, 8'h00, 8'h00, 8'h00);
      add_txn(REG_BUS_ADDR, 4'd2, ADDR_MIN, 8'h00, 8'h00);
      add_txn(REG_BUS_ADDR, 4'd2, ADDR_MAX, 8'h00, 8'h00);
      add_txn(REG_BUS_ADDR, 4'd2, ADDR_MAX, 8'h00, 8'h00);
      add_txn(REG_BUS_ADDR, 4'd2, 8'h07, 8'h00, 8'h00);
      add_txn(REG_UPDATE, 4'd2, 8'h00, 8'h00, 8'h00);
      add_txn(REG_UPDATE, 4'd2, 8'hFF, 8'h00, 8'h00);
      add_txn(8'h99, 4'd2, 8'h55, 8'h00, 8'h00);

      for (phase = 0; phase < 5; phase++) begin
         wait_drained();
         csr_we <= 1'b1;
         csr_wdata <= fw_values[phase];
         @(posedge clock);
         csr_we <= 1'b0;
         mirror_fw = fw_values[phase];
         fw_settings++;
         // the closing phase runs both channels at full rate
         if (phase == 4) idle_on = 1'b0;
         add_txn(REG_FW_VERSION, 4'd1, 8'h00, 8'h00, 8'h00);
         repeat (225) begin
            if ($urandom_range(0, 9) == 0) begin
               add_step(8'($urandom));
            end else begin
               if ($urandom_range(0, 99) < 85) addr = KNOWN_REGS[$urandom_range(0, 12)];
               else addr = 8'($urandom);
               pick = $urandom_range(0, 99);
               if (pick < 40) cnt = 4'd1;
               else if (pick < 75) cnt = 4'd2;
               else if (pick < 85) cnt = 4'd3;
               else if (pick < 93) cnt = 4'd4;
               else cnt = 4'($urandom);
               d0 = pick_data();
               if (addr == REG_SAVE && $urandom_range(0, 3) != 0) begin
                  d0 = $urandom_range(0, 1) ? SAVE_CMD_STEP : SAVE_CMD_RGB;
               end
               add_txn(addr, cnt, d0, pick_data(), pick_data());
            end
         end
      end
      wait_drained();

      $display("checked %0d transfers: %0d with read data, %0d save requests, %0d address changes",
               answers_checked, reads_answered, save_requests, addr_changes);
      $display("firmware version programmed %0d times, random stalls on both channels",
               fw_settings);
      if (mismatches == 0) begin
         $display("i2c_register_map_slave_core_tb: clean");
      end else begin
         $display("i2c_register_map_slave_core_tb: errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("i2c_register_map_slave_core_tb: errors");
      $finish;
   end

endmodule
